FILE: rtl/cassette_fsk_record_encoder_unit_assert.svh
// assertion macros for the cassette fsk record encoder
// depends on clk and rst_n being visible at the point of use
`ifndef CASSETTE_FSK_RECORD_ENCODER_UNIT_ASSERT_SVH
`define CASSETTE_FSK_RECORD_ENCODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define CFE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfe assertion failed");
`define CFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfe assertion failed");
`else
`define CFE_ASSERT_SAME(label, ante, cons)
`define CFE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/cfe_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the cassette fsk record encoder
// no dependencies
package cfe_pkg;

  localparam int DEFAULT_TIME_BITS = 32;
  localparam int COUNT_W = 40;

  localparam logic [1:0] CMD_REMOTE = 2'd0;
  localparam logic [1:0] CMD_DATA   = 2'd1;
  localparam logic [1:0] CMD_PULL   = 2'd2;

  localparam logic [1:0] LINE_IDLE  = 2'd0;
  localparam logic [1:0] LINE_MARK  = 2'd1;
  localparam logic [1:0] LINE_SPACE = 2'd2;

  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_MARK  = 2'd1;
  localparam logic [1:0] PEND_SPACE = 2'd2;
  localparam logic [1:0] PEND_IDLE  = 2'd3;

  localparam logic [1:0] REG_RECORD_ENABLE = 2'd0;
  localparam logic [1:0] REG_WAV_FORMAT    = 2'd1;
  localparam logic [1:0] REG_CPU_CLOCK_HZ  = 2'd2;

  localparam logic [31:0] CLOCK_HZ_RESET = 32'd2457600;
  localparam logic [15:0] MULT_TONE      = 16'd2400;
  localparam logic [15:0] MULT_IDLE      = 16'd48000;
  localparam logic [4:0]  MARK_HALF      = 5'd10;
  localparam logic [4:0]  SPACE_HALF     = 5'd20;
  localparam logic [6:0]  RUN_MAX        = 7'h7f;
  localparam logic [7:0]  SAMPLE_HIGH    = 8'hff;
  localparam logic [7:0]  SAMPLE_LOW     = 8'h00;
  localparam logic [7:0]  SAMPLE_MID     = 8'h80;

  typedef struct packed {
    logic busy;
    logic done;
  } cfe_div_stat_t;

endpackage

FILE: rtl/cfe_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for the encoder input and result streams
// no dependencies
interface cfe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic        level;
  logic [31:0] timestamp;
  modport source (output valid, command, level, timestamp, input ready);
  modport sink (input valid, command, level, timestamp, output ready);
endinterface

interface cfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       segment_end;
  logic       event_rejected;
  modport source (output valid, out_byte, byte_valid, segment_end, event_rejected,
                  input ready);
  modport sink (input valid, out_byte, byte_valid, segment_end, event_rejected,
                output ready);
endinterface

FILE: rtl/cassette_fsk_record_encoder_unit.sv
`timescale 1ns / 1ps
// cassette fsk record encoder, top level: sequencer, line state, byte generator
// depends on cfe_pkg, cfe_if, cfe_div and the assertion header
//
// usage
// in_if carries events (remote line, data line) and pull commands, each with a
// timestamp; every accepted transaction yields exactly one result on out_if.
// a pull returns the next audio byte (sample or run code) of the pending
// segment; an event that ends a segment while recording starts a conversion.
// the result is registered the cycle after acceptance. an event that ends a
// recorded segment keeps in_if.ready low while the sequencer steps through
// its multiply, load and divide states, where the bit-serial divider turns the
// segment length into a tone cycle or sample count; other transactions do not.
// a new transaction is taken while the result register is being
// drained; when out_if is stalled the result holds and in_if.ready stays low.
// cfg_we writes one register per cycle by cfg_index; the user must write only
// while idle, the block does not enforce it. reset: synchronous, active low;
// registers and line state return to their reset values, no clearing pass.

`include "cassette_fsk_record_encoder_unit_assert.svh"

module cassette_fsk_record_encoder_unit
  import cfe_pkg::*;
#(
  parameter int TIME_BITS = DEFAULT_TIME_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  cfe_in_if.sink      in_if,
  cfe_out_if.source   out_if,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int EW     = (TIME_BITS < 32) ? TIME_BITS : 32;
  localparam int PROD_W = EW + 16;
  localparam int NUM_W  = ((PROD_W > 33) ? PROD_W : 33) + 1;
  localparam int DEN_W  = 33;
  localparam int NW     = NUM_W + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;
  localparam logic [1:0] ST_DIV  = 2'd3;

  logic [1:0] state_r, state_nxt;

  logic        record_enable_r;
  logic        wav_format_r;
  logic [31:0] cpu_clock_hz_r;

  logic               remote_on_r, remote_on_nxt;
  logic [1:0]         line_kind_r, line_kind_nxt;
  logic [EW-1:0]      seg_start_r, seg_start_nxt;
  logic [1:0]         pend_kind_r, pend_kind_nxt;
  logic [COUNT_W-1:0] pend_count_r, pend_count_nxt;
  logic               half_phase_r, half_phase_nxt;
  logic [4:0]         half_left_r, half_left_nxt;

  logic [1:0]        emit_kind_r, emit_kind_nxt;
  logic [EW-1:0]     elapsed_r, elapsed_nxt;
  logic [PROD_W-1:0] prod_r;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] obyte_r, obyte_nxt;
  logic       bval_r, bval_nxt;
  logic       segend_r, segend_nxt;
  logic       rej_r, rej_nxt;

  logic          in_fire;
  logic          emit_tone;
  logic [15:0]   mult_k;
  logic [31:0]   clk_eff;
  logic          div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  cfe_div_stat_t div_stat;
  logic [NUM_W-1:0] div_quot;
  logic [NW+COUNT_W-1:0] n_ext;
  logic [COUNT_W-1:0]    n_sat;

  assign in_if.ready = (state_r == ST_IDLE) && (!out_valid_r || out_if.ready);
  assign in_fire     = in_if.valid && in_if.ready;

  assign emit_tone = (emit_kind_r == LINE_MARK) || (emit_kind_r == LINE_SPACE);
  assign mult_k    = emit_tone ? MULT_TONE : MULT_IDLE;
  assign clk_eff   = (cpu_clock_hz_r == 32'd0) ? 32'd1 : cpu_clock_hz_r;
  assign div_start = (state_r == ST_LOAD);
  assign div_num   = NUM_W'(prod_r) + (emit_tone ? NUM_W'(clk_eff) : NUM_W'(0));
  assign div_den   = emit_tone ? {clk_eff, 1'b0} : {1'b0, clk_eff};

  cfe_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  // mark counts two tone cycles per bit cell, then clamp to the counter width
  assign n_ext = (emit_kind_r == LINE_MARK) ? (NW + COUNT_W)'({div_quot, 1'b0})
                                            : (NW + COUNT_W)'(div_quot);
  assign n_sat = (|n_ext[NW+COUNT_W-1:COUNT_W]) ? {COUNT_W{1'b1}} : n_ext[COUNT_W-1:0];

  always_comb begin
    logic [4:0] left;
    logic [6:0] run_len;
    state_nxt      = state_r;
    remote_on_nxt  = remote_on_r;
    line_kind_nxt  = line_kind_r;
    seg_start_nxt  = seg_start_r;
    pend_kind_nxt  = pend_kind_r;
    pend_count_nxt = pend_count_r;
    half_phase_nxt = half_phase_r;
    half_left_nxt  = half_left_r;
    emit_kind_nxt  = emit_kind_r;
    elapsed_nxt    = elapsed_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    obyte_nxt      = obyte_r;
    bval_nxt       = bval_r;
    segend_nxt     = segend_r;
    rej_nxt        = rej_r;
    left           = '0;
    run_len        = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          out_valid_nxt = 1'b1;
          obyte_nxt     = 8'h00;
          bval_nxt      = 1'b0;
          segend_nxt    = 1'b0;
          rej_nxt       = 1'b0;
          unique case (in_if.command)
            CMD_REMOTE, CMD_DATA: begin
              if (pend_kind_r != PEND_NONE) begin
                rej_nxt = 1'b1;
              end else begin
                if (in_if.command == CMD_REMOTE) begin
                  if (!remote_on_r && in_if.level) begin
                    line_kind_nxt = LINE_IDLE;
                    seg_start_nxt = in_if.timestamp[EW-1:0];
                  end else if (remote_on_r && !in_if.level && record_enable_r) begin
                    state_nxt = ST_MUL;
                  end
                  remote_on_nxt = in_if.level;
                end else begin
                  if (remote_on_r && record_enable_r) begin
                    state_nxt = ST_MUL;
                  end
                  line_kind_nxt = in_if.level ? LINE_MARK : LINE_SPACE;
                  seg_start_nxt = in_if.timestamp[EW-1:0];
                end
                emit_kind_nxt = line_kind_r;
                elapsed_nxt   = in_if.timestamp[EW-1:0] - seg_start_r;
              end
            end
            CMD_PULL: begin
              if (pend_kind_r == PEND_IDLE) begin
                bval_nxt = 1'b1;
                if (wav_format_r) begin
                  obyte_nxt      = SAMPLE_MID;
                  pend_count_nxt = pend_count_r - 1'b1;
                end else begin
                  run_len = (pend_count_r < COUNT_W'(RUN_MAX)) ? pend_count_r[6:0]
                                                               : RUN_MAX;
                  obyte_nxt      = {1'b0, run_len};
                  pend_count_nxt = pend_count_r - COUNT_W'(run_len);
                end
                if (pend_count_nxt == '0) begin
                  pend_kind_nxt = PEND_NONE;
                  segend_nxt    = 1'b1;
                end
              end else if (pend_kind_r != PEND_NONE) begin
                bval_nxt = 1'b1;
                left = (half_left_r != 5'd0) ? half_left_r
                     : ((pend_kind_r == PEND_MARK) ? MARK_HALF : SPACE_HALF);
                if (wav_format_r) begin
                  obyte_nxt = half_phase_r ? SAMPLE_LOW : SAMPLE_HIGH;
                  left      = left - 5'd1;
                end else begin
                  obyte_nxt = {~half_phase_r, 2'b00, left};
                  left      = 5'd0;
                end
                half_left_nxt = left;
                if (left == 5'd0) begin
                  if (!half_phase_r) begin
                    half_phase_nxt = 1'b1;
                  end else begin
                    half_phase_nxt = 1'b0;
                    pend_count_nxt = pend_count_r - 1'b1;
                    if (pend_count_nxt == '0) begin
                      pend_kind_nxt = PEND_NONE;
                      segend_nxt    = 1'b1;
                    end
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MUL: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt      = ST_IDLE;
          pend_kind_nxt  = emit_tone ? emit_kind_r : PEND_IDLE;
          pend_count_nxt = n_sat;
          half_phase_nxt = 1'b0;
          half_left_nxt  = 5'd0;
          if (n_sat == '0) begin
            pend_kind_nxt = PEND_NONE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      record_enable_r <= 1'b0;
      wav_format_r    <= 1'b0;
      cpu_clock_hz_r  <= CLOCK_HZ_RESET;
      remote_on_r     <= 1'b0;
      line_kind_r     <= LINE_IDLE;
      seg_start_r     <= '0;
      pend_kind_r     <= PEND_NONE;
      pend_count_r    <= '0;
      half_phase_r    <= 1'b0;
      half_left_r     <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      remote_on_r  <= remote_on_nxt;
      line_kind_r  <= line_kind_nxt;
      seg_start_r  <= seg_start_nxt;
      pend_kind_r  <= pend_kind_nxt;
      pend_count_r <= pend_count_nxt;
      half_phase_r <= half_phase_nxt;
      half_left_r  <= half_left_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RECORD_ENABLE: record_enable_r <= cfg_data[0];
          REG_WAV_FORMAT:    wav_format_r    <= cfg_data[0];
          REG_CPU_CLOCK_HZ:  cpu_clock_hz_r  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
    emit_kind_r <= emit_kind_nxt;
    elapsed_r   <= elapsed_nxt;
    prod_r      <= PROD_W'(elapsed_r) * PROD_W'(mult_k);
    obyte_r     <= obyte_nxt;
    bval_r      <= bval_nxt;
    segend_r    <= segend_nxt;
    rej_r       <= rej_nxt;
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.out_byte       = obyte_r;
  assign out_if.byte_valid     = bval_r;
  assign out_if.segment_end    = segend_r;
  assign out_if.event_rejected = rej_r;

  `CFE_ASSERT_SAME(a_done_in_div, div_stat.done, state_r == ST_DIV)
  `CFE_ASSERT_SAME(a_count_kind, 1'b1, (pend_kind_r == PEND_NONE) == (pend_count_r == '0))
  `CFE_ASSERT_SAME(a_half_bound, 1'b1, half_left_r <= SPACE_HALF)
  `CFE_ASSERT_SAME(a_conv_no_pend, state_r == ST_MUL, pend_kind_r == PEND_NONE)
  `CFE_ASSERT_NEXT(a_load_busy, state_r == ST_LOAD, div_stat.busy)
  `CFE_ASSERT_SAME(a_segend_byte, out_valid_r && segend_r, bval_r && !rej_r)

endmodule

FILE: rtl/cfe_div.sv
`timescale 1ns / 1ps
// iterative restoring divider, one quotient bit per cycle
// depends on cfe_pkg
module cfe_div
  import cfe_pkg::*;
#(
  parameter int NUM_W = 49,
  parameter int DEN_W = 33
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output cfe_div_stat_t    stat,
  output logic [NUM_W-1:0] quot
);

  localparam int CW = $clog2(NUM_W);
  localparam logic [CW-1:0] LAST = CW'(NUM_W - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;

  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = fits ? (rem_sh - {1'b0, den_r}) : rem_sh;
      quo_nxt = {quo_r[NUM_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quo_r;

endmodule

FILE: tb/cfe_audio_checker.sv
`timescale 1ns / 1ps
// scoreboard for the cassette fsk record encoder: mirrors line and audio state,
// predicts every result and compares it; depends on cfe_pkg and the cfe_if channels
module cfe_audio_checker
  import cfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  cfe_in_if           in_mon,
  cfe_out_if          out_mon,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        audio_pending,
  output int          results_due,
  output int          mismatch_count
);

  localparam logic [63:0] COUNT_LIMIT = (64'd1 << COUNT_W) - 64'd1;
  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       segment_end;
    logic       event_rejected;
  } audio_result_t;

  audio_result_t expected_q[$];
  int error_total = 0;

  logic              rec_en;
  logic              wav_mode;
  logic [31:0]       clock_hz;
  logic              remote_on;
  logic [1:0]        line_kind;
  logic [31:0]       seg_start;
  logic [1:0]        pend_kind;
  logic [COUNT_W-1:0] pend_count;
  logic              half_low;
  logic [4:0]        half_left;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_total < PRINT_LIMIT)
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_total++;
  endtask

  task automatic close_segment(input logic [31:0] now);
    logic [31:0] elapsed;
    logic [63:0] divisor;
    logic [63:0] cycles;
    if (rec_en && remote_on) begin
      elapsed = now - seg_start;
      divisor = (clock_hz == 32'd0) ? 64'd1 : {32'd0, clock_hz};
      if (line_kind == LINE_MARK || line_kind == LINE_SPACE) begin
        cycles = ({48'd0, MULT_TONE} * {32'd0, elapsed} + divisor) / (divisor * 64'd2);
        if (line_kind == LINE_MARK) begin
          cycles = cycles * 64'd2;
          pend_kind = PEND_MARK;
        end else begin
          pend_kind = PEND_SPACE;
        end
      end else begin
        cycles = ({48'd0, MULT_IDLE} * {32'd0, elapsed}) / divisor;
        pend_kind = PEND_IDLE;
      end
      if (cycles > COUNT_LIMIT) cycles = COUNT_LIMIT;
      pend_count = cycles[COUNT_W-1:0];
      half_low = 1'b0;
      half_left = 5'd0;
      if (cycles == 64'd0) pend_kind = PEND_NONE;
    end
  endtask

  task automatic predict_result(input logic [1:0] cmd, input logic lvl, input logic [31:0] ts,
                                output audio_result_t r);
    logic [4:0] left;
    logic [6:0] run;
    r = '0;
    case (cmd)
      CMD_REMOTE, CMD_DATA: begin
        if (pend_kind != PEND_NONE) begin
          r.event_rejected = 1'b1;
        end else if (cmd == CMD_REMOTE) begin
          if (!remote_on && lvl) begin
            line_kind = LINE_IDLE;
            seg_start = ts;
          end else if (remote_on && !lvl) begin
            close_segment(ts);
          end
          remote_on = lvl;
        end else begin
          if (remote_on) close_segment(ts);
          line_kind = lvl ? LINE_MARK : LINE_SPACE;
          seg_start = ts;
        end
      end
      CMD_PULL: begin
        if (pend_kind == PEND_IDLE) begin
          r.byte_valid = 1'b1;
          if (wav_mode) begin
            r.out_byte = SAMPLE_MID;
            pend_count = pend_count - 1'b1;
          end else begin
            run = (pend_count < RUN_MAX) ? pend_count[6:0] : RUN_MAX;
            r.out_byte = {1'b0, run};
            pend_count = pend_count - {{(COUNT_W-7){1'b0}}, run};
          end
          if (pend_count == '0) begin
            pend_kind = PEND_NONE;
            r.segment_end = 1'b1;
          end
        end else if (pend_kind != PEND_NONE) begin
          r.byte_valid = 1'b1;
          left = (half_left != 5'd0) ? half_left
               : ((pend_kind == PEND_MARK) ? MARK_HALF : SPACE_HALF);
          if (wav_mode) begin
            r.out_byte = half_low ? SAMPLE_LOW : SAMPLE_HIGH;
            left = left - 5'd1;
          end else begin
            r.out_byte = {~half_low, 2'b00, left};
            left = 5'd0;
          end
          half_left = left;
          if (left == 5'd0) begin
            if (!half_low) begin
              half_low = 1'b1;
            end else begin
              half_low = 1'b0;
              pend_count = pend_count - 1'b1;
              if (pend_count == '0) begin
                pend_kind = PEND_NONE;
                r.segment_end = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    audio_result_t want;
    audio_result_t got;
    if (!rst_n) begin
      rec_en = 1'b0;
      wav_mode = 1'b0;
      clock_hz = CLOCK_HZ_RESET;
      remote_on = 1'b0;
      line_kind = LINE_IDLE;
      seg_start = 32'd0;
      pend_kind = PEND_NONE;
      pend_count = '0;
      half_low = 1'b0;
      half_left = 5'd0;
      expected_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.out_byte, out_mon.byte_valid, out_mon.segment_end,
               out_mon.event_rejected};
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transaction", got, 0);
        end else begin
          want = expected_q.pop_front();
          if (got.out_byte !== want.out_byte)
            report_mismatch("out_byte", got.out_byte, want.out_byte);
          if (got.byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", got.byte_valid, want.byte_valid);
          if (got.segment_end !== want.segment_end)
            report_mismatch("segment_end", got.segment_end, want.segment_end);
          if (got.event_rejected !== want.event_rejected)
            report_mismatch("event_rejected", got.event_rejected, want.event_rejected);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_RECORD_ENABLE: rec_en = cfg_data[0];
          REG_WAV_FORMAT:    wav_mode = cfg_data[0];
          REG_CPU_CLOCK_HZ:  clock_hz = cfg_data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_result(in_mon.command, in_mon.level, in_mon.timestamp, want);
        expected_q.push_back(want);
      end
    end
    audio_pending <= (pend_kind != PEND_NONE);
    results_due <= expected_q.size();
    mismatch_count <= error_total;
  end

endmodule

FILE: tb/cassette_fsk_record_encoder_unit_tb.sv
`timescale 1ns / 1ps
// stimulus and verdict for the cassette fsk record encoder: directed cases, random
// phases over several register settings; depends on cfe_pkg, cfe_if, the rtl, the checker
module cassette_fsk_record_encoder_unit_tb;
  import cfe_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int RANDOM_ITEMS = 1200;
  localparam int NUM_PHASES = 7;
  localparam int DRAIN_GUARD = 2000;
  localparam int END_SETTLE = 60;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  cfe_in_if  in_ch();
  cfe_out_if out_ch();

  logic audio_pending;
  int   results_due;
  int   mismatch_count;

  int          sent_items = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b0;
  int          stall_mode = 0;
  int          ready_hold = 0;
  logic        ready_level = 1'b1;
  logic [31:0] clock_hz_cur = CLOCK_HZ_RESET;
  logic        wav_cur = 1'b0;
  logic [31:0] now_ts = 32'd0;
  logic [31:0] base_ts;
  logic [31:0] hz;
  logic [1:0]  cmd;
  int          phase_end;
  int          max_bits;

  // phases 5 and 6 pick a random rate; their zero entries in phase_hz are unused
  bit          phase_rec   [NUM_PHASES] = '{1, 1, 0, 1, 1, 1, 1};
  bit          phase_wav   [NUM_PHASES] = '{0, 1, 0, 0, 0, 1, 0};
  int          phase_bits  [NUM_PHASES] = '{3, 1, 3, 3, 3, 1, 3};
  bit          phase_gaps  [NUM_PHASES] = '{1, 1, 0, 1, 1, 1, 1};
  int          phase_stall [NUM_PHASES] = '{1, 2, 1, 0, 2, 1, 2};
  logic [31:0] phase_hz    [NUM_PHASES] = '{32'd2457600, 32'd2457600, 32'd4000000,
                                            32'hFFFF_FFFF, 32'd1200, 32'd0, 32'd0};

  always #10 clk = ~clk;

  cassette_fsk_record_encoder_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cfe_audio_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .audio_pending  (audio_pending),
    .results_due    (results_due),
    .mismatch_count (mismatch_count)
  );

  always @(posedge clk) begin
    logic next_ready;
    if (stall_mode == 0) begin
      next_ready = 1'b1;
    end else begin
      if (ready_hold == 0) begin
        ready_level = !ready_level;
        ready_hold = ready_level ? $urandom_range(1, 10)
                                 : $urandom_range(1, (stall_mode == 1) ? 3 : 12);
      end
      ready_hold--;
      next_ready = ready_level;
    end
    out_ch.ready <= next_ready;
  end

  task automatic send_item(input logic [1:0] c, input logic l, input logic [31:0] ts);
    int gap;
    if (burst_left == 0) begin
      burst_left = gaps_on ? $urandom_range(1, 16) : 1000;
      gap = gaps_on ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.command <= c;
    in_ch.level <= l;
    in_ch.timestamp <= ts;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sent_items++;
  endtask

  task automatic send_pull();
    send_item(CMD_PULL, 1'($urandom_range(0, 1)), $urandom());
  endtask

  // waits for every result and for any conversion still running
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0 || !in_ch.ready);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_config(input logic rec, input logic wav, input logic [31:0] rate);
    wait_drained();
    write_reg(REG_RECORD_ENABLE, {31'd0, rec});
    write_reg(REG_WAV_FORMAT, {31'd0, wav});
    write_reg(REG_CPU_CLOCK_HZ, rate);
    wav_cur = wav;
    clock_hz_cur = rate;
  endtask

  // pulls until the segment is out, flipping the byte format mid-segment now and then
  task automatic drain_audio();
    int guard;
    guard = 0;
    do begin
      send_pull();
      guard++;
      if (audio_pending && $urandom_range(0, 39) == 0) begin
        wait_drained();
        write_reg(REG_WAV_FORMAT, {31'd0, !wav_cur});
        wav_cur = !wav_cur;
      end
    end while (audio_pending && guard < DRAIN_GUARD);
  endtask

  function automatic logic [31:0] seg_delta(input int bits);
    logic [31:0] bit_clocks;
    bit_clocks = clock_hz_cur / 32'd1200;
    if (bit_clocks == 32'd0) bit_clocks = 32'd1;
    return bit_clocks * $urandom_range(0, bits) + $urandom_range(0, bit_clocks);
  endfunction

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.command <= CMD_PULL;
    in_ch.level <= 1'b0;
    in_ch.timestamp <= 32'd0;
    cfg_we <= 1'b0;
    cfg_index <= REG_RECORD_ENABLE;
    cfg_data <= 32'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty pulls, rejection, rounding edges, wrap, format change mid-tone
    write_config(1'b1, 1'b0, CLOCK_HZ_RESET);
    send_item(CMD_PULL, 1'b1, 32'hFFFF_FFFF);
    send_item(CMD_UNKNOWN, 1'b1, 32'd0);
    send_item(CMD_DATA, 1'b1, 32'd100);
    send_item(CMD_REMOTE, 1'b1, 32'd1000);
    send_item(CMD_REMOTE, 1'b0, 32'd3048);
    send_item(CMD_DATA, 1'b0, 32'd3100);
    send_item(CMD_REMOTE, 1'b1, 32'd3200);
    send_item(CMD_PULL, 1'b0, 32'd0);
    base_ts = 32'hFFFF_FB00;
    send_item(CMD_REMOTE, 1'b1, base_ts);
    send_item(CMD_DATA, 1'b1, base_ts + 32'd10);
    send_item(CMD_DATA, 1'b0, base_ts + 32'd1034);
    repeat (4) send_pull();
    send_item(CMD_DATA, 1'b1, base_ts + 32'd2057);
    send_item(CMD_REMOTE, 1'b0, base_ts + 32'd3081);
    write_config(1'b1, 1'b1, CLOCK_HZ_RESET);
    repeat (2) send_pull();
    write_config(1'b1, 1'b0, CLOCK_HZ_RESET);
    repeat (4) send_pull();
    send_item(CMD_PULL, 1'b0, 32'd0);
    send_item(CMD_UNKNOWN, 1'b0, 32'hFFFF_FFFF);
    now_ts = base_ts + 32'd4000;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      hz = phase_hz[phase];
      if (phase == 5) hz = $urandom_range(10000000, 48000);
      if (phase == 6) hz = $urandom_range(32'hFFFF_FFFF, 1200);
      write_config(phase_rec[phase], phase_wav[phase], hz);
      gaps_on = phase_gaps[phase];
      stall_mode <= phase_stall[phase];
      max_bits = phase_bits[phase];
      phase_end = sent_items + RANDOM_ITEMS / NUM_PHASES;
      while (sent_items < phase_end) begin
        if ($urandom_range(0, 9) < 7) begin
          drain_audio();
          now_ts = now_ts + seg_delta(max_bits);
          send_item(CMD_REMOTE, 1'b1, now_ts);
          repeat ($urandom_range(0, 4)) begin
            now_ts = now_ts + seg_delta(max_bits);
            send_item(CMD_DATA, 1'($urandom_range(0, 1)), now_ts);
            drain_audio();
          end
          if ($urandom_range(0, 3) != 0) begin
            now_ts = now_ts + seg_delta(max_bits);
            send_item(CMD_REMOTE, 1'b0, now_ts);
            drain_audio();
            if ($urandom_range(0, 3) == 0) now_ts = $urandom();
          end
        end else begin
          repeat ($urandom_range(1, 6)) begin
            cmd = 2'($urandom_range(0, 3));
            if (cmd == CMD_REMOTE || cmd == CMD_DATA) begin
              now_ts = now_ts + seg_delta(0);
              send_item(cmd, 1'($urandom_range(0, 1)), now_ts);
            end else begin
              send_item(cmd, 1'($urandom_range(0, 1)), $urandom());
            end
          end
        end
      end
    end

    // zero clock rate and a saturated tone count, left pending to the end
    drain_audio();
    now_ts = now_ts + seg_delta(0);
    send_item(CMD_REMOTE, 1'b0, now_ts);
    drain_audio();
    write_config(1'b1, 1'b0, 32'd0);
    stall_mode <= 2;
    gaps_on = 1'b1;
    send_item(CMD_REMOTE, 1'b1, now_ts);
    send_item(CMD_DATA, 1'b1, now_ts);
    send_item(CMD_DATA, 1'b0, now_ts - 32'd1);
    repeat (5) send_pull();
    send_item(CMD_DATA, 1'b1, now_ts + 32'd5);
    send_item(CMD_UNKNOWN, 1'b0, now_ts);
    send_pull();

    wait_drained();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
